@@ rtl/afbd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afbd_pkg: shared types and constants of the anchor-free box decoder
// Field widths, register indexes and reset values, and the bundles that
// pass between the decoder stages.
// ----------------------------------------------------------------------------
package afbd_pkg;

    localparam int MAX_CLASSES_DEF = 16;
    localparam int NUM_BOX_CH      = 4;

    localparam int CH_W     = 5;
    localparam int VAL_W    = 18;
    localparam int COORD_W  = 20;
    localparam int CLASS_W  = 5;
    localparam int SCORE_W  = 17;
    localparam int NCLS_W   = 5;
    localparam int THR_W    = 16;
    localparam int SCALE_W  = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Q13.4 x Q4.12 product (scale is unsigned, so one extra sign bit)
    localparam int PROD_W = VAL_W + SCALE_W + 1;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CLASSES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_THR   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y     = CFG_IDX_W'(3);

    // Reset values
    localparam logic [NCLS_W-1:0]  NUM_CLASSES_RST = NCLS_W'(7);
    localparam logic [THR_W-1:0]   SCORE_THR_RST   = THR_W'(16384);
    localparam logic [SCALE_W-1:0] SCALE_RST       = SCALE_W'(4096);
    localparam logic signed [CLASS_W-1:0] NO_CLASS = '1;

    // Rounding and range of the Q16.4 result
    localparam int ROUND_SHIFT = 12;
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(2048);
    localparam int SHIFTED_W = PROD_W - ROUND_SHIFT;
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] MIN_SIZE  = COORD_W'(16);

    typedef struct packed {
        logic [NCLS_W-1:0]  num_classes;
        logic [THR_W-1:0]   score_threshold;
        logic [SCALE_W-1:0] scale_x;
        logic [SCALE_W-1:0] scale_y;
    } cfg_t;

    // One decided anchor: raw products plus the winning class
    typedef struct packed {
        logic signed [PROD_W-1:0]  cx_prod;
        logic signed [PROD_W-1:0]  cy_prod;
        logic signed [PROD_W-1:0]  w_prod;
        logic signed [PROD_W-1:0]  h_prod;
        logic signed [CLASS_W-1:0] class_id;
        logic [SCORE_W-1:0]        score;
    } dec_t;

endpackage
`default_nettype wire

@@ rtl/afbd_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afbd_in_if: head value channel
// One detector-head value with its channel number.
// ----------------------------------------------------------------------------
interface afbd_in_if
    import afbd_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [CH_W-1:0]         channel;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output channel, output value, input ready);
    modport sink   (input valid, input channel, input value, output ready);
endinterface
`default_nettype wire

@@ rtl/afbd_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afbd_out_if: detection channel
// One kept detection: scaled box, class and score.
// ----------------------------------------------------------------------------
interface afbd_out_if
    import afbd_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] box_width;
    logic signed [COORD_W-1:0] box_height;
    logic signed [CLASS_W-1:0] class_id;
    logic [SCORE_W-1:0]        score;

    modport source (output valid, output center_x, output center_y, output box_width,
                    output box_height, output class_id, output score, input ready);
    modport sink   (input valid, input center_x, input center_y, input box_width,
                    input box_height, input class_id, input score, output ready);
endinterface
`default_nettype wire

@@ rtl/afbd_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afbd_cfg_if: register write channel
// Register index and write data.
// ----------------------------------------------------------------------------
interface afbd_cfg_if
    import afbd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/afbd_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afbd_cfg_regs: configuration registers
// Class count, score threshold and the two scale factors.
// ----------------------------------------------------------------------------
module afbd_cfg_regs
    import afbd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    afbd_cfg_if.sink    cfg,
    output cfg_t        regs
);

    cfg_t regs_reg;
    logic wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.num_classes     <= NUM_CLASSES_RST;
            regs_reg.score_threshold <= SCORE_THR_RST;
            regs_reg.scale_x         <= SCALE_RST;
            regs_reg.scale_y         <= SCALE_RST;
        end
        else if (wr)
        begin
            case (cfg.index)
                REG_NUM_CLASSES: regs_reg.num_classes     <= cfg.data[NCLS_W-1:0];
                REG_SCORE_THR:   regs_reg.score_threshold <= cfg.data[THR_W-1:0];
                REG_SCALE_X:     regs_reg.scale_x         <= cfg.data[SCALE_W-1:0];
                REG_SCALE_Y:     regs_reg.scale_y         <= cfg.data[SCALE_W-1:0];
                default:         ;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/afbd_accum.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afbd_accum: input register, box store and running class maximum
// On the last class channel it registers the four scaled products and the
// winning class for the output stage.
// ----------------------------------------------------------------------------
module afbd_accum
    import afbd_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    afbd_in_if.sink     item,
    input  cfg_t        regs,
    output logic        dec_valid,
    output dec_t        dec,
    input  wire logic   dec_ready
);

    localparam int NW    = $clog2(MAX_CLASSES + 1);
    localparam int CMP_W = (NW > CH_W) ? NW : CH_W;

    logic                    a_valid_reg;
    logic [CH_W-1:0]         a_channel_reg;
    logic signed [VAL_W-1:0] a_value_reg;

    logic signed [VAL_W-1:0] box_reg [NUM_BOX_CH];
    logic [SCORE_W-1:0]        best_score_reg;
    logic signed [CLASS_W-1:0] best_class_reg;

    logic b_valid_reg;
    dec_t b_reg;

    logic [CMP_W-1:0]          n_eff;
    logic [CMP_W-1:0]          k;
    logic                      is_box;
    logic                      in_range;
    logic                      is_last;
    logic                      better;
    logic [SCORE_W-1:0]        score_upd;
    logic signed [CLASS_W-1:0] class_upd;
    logic                      b_free;
    logic                      a_adv;
    logic                      a_load;

    // Class count: zero counts as one, clamped to MAX_CLASSES
    always_comb
    begin
        if (int'(regs.num_classes) > MAX_CLASSES)
            n_eff = CMP_W'(MAX_CLASSES);
        else if (regs.num_classes == '0)
            n_eff = CMP_W'(1);
        else
            n_eff = CMP_W'(regs.num_classes);
    end

    assign is_box   = (a_channel_reg < CH_W'(NUM_BOX_CH));
    assign k        = CMP_W'(a_channel_reg - CH_W'(NUM_BOX_CH));
    assign in_range = !is_box && (k < n_eff);
    assign is_last  = in_range && (k == n_eff - CMP_W'(1));

    // Strictly greater wins, so the first maximum is kept
    assign better    = in_range && !a_value_reg[VAL_W-1]
                       && (a_value_reg[SCORE_W-1:0] > best_score_reg);
    assign score_upd = better ? a_value_reg[SCORE_W-1:0] : best_score_reg;
    assign class_upd = better ? CLASS_W'(k) : best_class_reg;

    assign b_free = !b_valid_reg || dec_ready;
    assign a_adv  = a_valid_reg && (!is_last || b_free);

    assign item.ready = !a_valid_reg || a_adv;
    assign a_load     = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_load)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_channel_reg <= item.channel;
            a_value_reg   <= item.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BOX_CH; i++)
            begin
                box_reg[i] <= '0;
            end
            best_score_reg <= '0;
            best_class_reg <= NO_CLASS;
        end
        else if (a_adv)
        begin
            if (is_box)
            begin
                box_reg[a_channel_reg[1:0]] <= a_value_reg;
                if (a_channel_reg[1:0] == 2'd0)
                begin
                    best_score_reg <= '0;
                    best_class_reg <= NO_CLASS;
                end
            end
            else if (is_last)
            begin
                best_score_reg <= '0;
                best_class_reg <= NO_CLASS;
            end
            else if (in_range)
            begin
                best_score_reg <= score_upd;
                best_class_reg <= class_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (a_adv && is_last)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (dec_ready)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    // Four independent 18x17 products, one per box channel
    always_ff @(posedge clk)
    begin
        if (a_adv && is_last)
        begin
            b_reg.cx_prod  <= PROD_W'(box_reg[0]) * signed'({1'b0, regs.scale_x});
            b_reg.cy_prod  <= PROD_W'(box_reg[1]) * signed'({1'b0, regs.scale_y});
            b_reg.w_prod   <= PROD_W'(box_reg[2]) * signed'({1'b0, regs.scale_x});
            b_reg.h_prod   <= PROD_W'(box_reg[3]) * signed'({1'b0, regs.scale_y});
            b_reg.class_id <= class_upd;
            b_reg.score    <= score_upd;
        end
    end

    assign dec_valid = b_valid_reg;
    assign dec       = b_reg;

endmodule
`default_nettype wire

@@ rtl/afbd_emit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afbd_emit: rounding, saturation, keep test and output register
// ----------------------------------------------------------------------------
module afbd_emit
    import afbd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   dec_valid,
    input  dec_t        dec,
    output logic        dec_ready,
    input  cfg_t        regs,
    afbd_out_if.source  det
);

    // Round half up to Q16.4 (floor shift), then clamp to 20 bits signed
    function automatic logic signed [COORD_W-1:0] round_sat(logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0]    biased;
        logic signed [SHIFTED_W-1:0] r;
        biased = p + ROUND_BIAS;
        r      = SHIFTED_W'(biased >>> ROUND_SHIFT);
        if (r > SHIFTED_W'(COORD_MAX))
            return COORD_MAX;
        else if (r < SHIFTED_W'(COORD_MIN))
            return COORD_MIN;
        else
            return COORD_W'(r);
    endfunction

    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] w;
    logic signed [COORD_W-1:0] h;
    logic                      keep;
    logic                      o_free;
    logic                      o_load;

    logic                      o_valid_reg;
    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic signed [COORD_W-1:0] w_reg;
    logic signed [COORD_W-1:0] h_reg;
    logic signed [CLASS_W-1:0] class_reg;
    logic [SCORE_W-1:0]        score_reg;

    assign cx   = round_sat(dec.cx_prod);
    assign cy   = round_sat(dec.cy_prod);
    assign w    = round_sat(dec.w_prod);
    assign h    = round_sat(dec.h_prod);
    assign keep = (dec.score >= SCORE_W'(regs.score_threshold))
                  && (w >= MIN_SIZE) && (h >= MIN_SIZE);

    assign o_free    = !o_valid_reg || det.ready;
    assign dec_ready = !keep || o_free;   // dropped anchors leave at once
    assign o_load    = dec_valid && keep && o_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_load)
        begin
            o_valid_reg <= 1'b1;
        end
        else if (det.ready)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_load)
        begin
            cx_reg    <= cx;
            cy_reg    <= cy;
            w_reg     <= w;
            h_reg     <= h;
            class_reg <= dec.class_id;
            score_reg <= dec.score;
        end
    end

    assign det.valid      = o_valid_reg;
    assign det.center_x   = cx_reg;
    assign det.center_y   = cy_reg;
    assign det.box_width  = w_reg;
    assign det.box_height = h_reg;
    assign det.class_id   = class_reg;
    assign det.score      = score_reg;

endmodule
`default_nettype wire

@@ rtl/anchor_free_box_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anchor_free_box_decode: anchor-free detection decoder
// Collects one anchor's box and class scores and emits at most one detection.
// ----------------------------------------------------------------------------
// Feed head values per anchor: channels 0..3 (center x, center y, width,
// height, Q13.4), then channels 4.. carrying class scores (Q1.16). The block
// takes one value per clock; item.ready stays high while a finished detection
// waits on det, and only drops when the output register is full, not taken,
// and a last-class value is also waiting behind the product register. A
// detection's last class value is loaded into the input register, then
// into the product register (four 18x17 multipliers), and then into the
// output register behind rounding, saturation and the keep test. Channel 0
// starts a new anchor and clears the running maximum; the last class channel
// decides and clears it; class channels past the class count are ignored.
// Registers (cfg index): 0 num_classes (0 counts as one, clamped to
// MAX_CLASSES), 1 score_threshold Q0.16, 2 scale_x Q4.12, 3 scale_y Q4.12.
// cfg.ready is always high; write registers only while no detection is in
// flight.
// ----------------------------------------------------------------------------
module anchor_free_box_decode
    import afbd_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    afbd_cfg_if.sink    cfg,
    afbd_in_if.sink     item,
    afbd_out_if.source  det
);

    cfg_t regs;
    logic dec_valid;
    logic dec_ready;
    dec_t dec;

    // Register file
    afbd_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // Box store, class maximum and product stage
    afbd_accum #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .regs      (regs),
        .dec_valid (dec_valid),
        .dec       (dec),
        .dec_ready (dec_ready)
    );

    // Round, saturate, filter and hold the detection
    afbd_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_valid (dec_valid),
        .dec       (dec),
        .dec_ready (dec_ready),
        .regs      (regs),
        .det       (det)
    );

endmodule
`default_nettype wire

@@ tb/afbd_detection_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afbd_detection_checker: detection predictor and comparator
// Watches the register, head value and detection channels. Keeps its own
// copy of the decoder state, works out the detection that each transferred
// head value causes, and compares detections in order as they leave.
// ----------------------------------------------------------------------------
module afbd_detection_checker
    import afbd_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    afbd_cfg_if  cfg,
    afbd_in_if   item,
    afbd_out_if  det,
    output int   mismatches,
    output int   dets_due
);

    localparam logic [CH_W-1:0] CH_CENTER_X  = '0;
    localparam int              REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] box_width;
        logic signed [COORD_W-1:0] box_height;
        logic signed [CLASS_W-1:0] class_id;
        logic [SCORE_W-1:0]        score;
    } detection_t;

    detection_t                detections_due [$];
    cfg_t                      regs;
    // held box: center x, center y, width, height (Q13.4)
    logic signed [VAL_W-1:0]   box_vals [NUM_BOX_CH];
    logic [SCORE_W-1:0]        top_score;
    logic signed [CLASS_W-1:0] top_class;

    // Q13.4 x Q4.12 -> Q16.4, round half up, saturate
    function automatic logic signed [COORD_W-1:0] to_frame(
        input logic signed [VAL_W-1:0] v,
        input logic [SCALE_W-1:0]      s
    );
        longint prod;
        prod = (longint'(v) * longint'(s) + (longint'(1) << (ROUND_SHIFT - 1)))
               >>> ROUND_SHIFT;
        if (prod > longint'(COORD_MAX))
            return COORD_MAX;
        if (prod < longint'(COORD_MIN))
            return COORD_MIN;
        return COORD_W'(prod);
    endfunction

    function automatic void absorb_head_value(
        input logic [CH_W-1:0]         ch,
        input logic signed [VAL_W-1:0] v
    );
        int         n_cls;
        int         k;
        detection_t d;
        n_cls = int'(regs.num_classes);
        if (n_cls == 0)
            n_cls = 1;
        if (n_cls > MAX_CLASSES)
            n_cls = MAX_CLASSES;
        if (ch < NUM_BOX_CH) begin
            if (ch == CH_CENTER_X) begin
                top_score = '0;
                top_class = NO_CLASS;
            end
            box_vals[ch] = v;
            return;
        end
        k = int'(ch) - NUM_BOX_CH;
        if (k >= n_cls)
            return;
        // strictly greater: first maximum wins, non-positive never wins
        if (longint'(v) > longint'(top_score)) begin
            top_score = SCORE_W'(v);
            top_class = CLASS_W'(k);
        end
        if (k != n_cls - 1)
            return;
        d.center_x   = to_frame(box_vals[0], regs.scale_x);
        d.center_y   = to_frame(box_vals[1], regs.scale_y);
        d.box_width  = to_frame(box_vals[2], regs.scale_x);
        d.box_height = to_frame(box_vals[3], regs.scale_y);
        d.class_id   = top_class;
        d.score      = top_score;
        if (top_score >= regs.score_threshold && d.box_width >= MIN_SIZE
            && d.box_height >= MIN_SIZE)
            detections_due = {detections_due, d};
        top_score = '0;
        top_class = NO_CLASS;
    endfunction

    function automatic void check_detection();
        detection_t got;
        detection_t want;
        got.center_x   = det.center_x;
        got.center_y   = det.center_y;
        got.box_width  = det.box_width;
        got.box_height = det.box_height;
        got.class_id   = det.class_id;
        got.score      = det.score;
        if (detections_due.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
                $display("[%0t] detection with none outstanding: cx=%0d cy=%0d w=%0d h=%0d"
                         , $time, got.center_x, got.center_y, got.box_width,
                         got.box_height, " class=%0d score=%0d", got.class_id, got.score);
            mismatches++;
            return;
        end
        want = detections_due.pop_front();
        if (got.center_x !== want.center_x || got.center_y !== want.center_y
            || got.box_width !== want.box_width || got.box_height !== want.box_height
            || got.class_id !== want.class_id || got.score !== want.score) begin
            if (mismatches < REPORT_LIMIT) begin
                $display("[%0t] detection mismatch", $time);
                $display("  expected cx=%0d cy=%0d w=%0d h=%0d class=%0d score=%0d",
                         want.center_x, want.center_y, want.box_width, want.box_height,
                         want.class_id, want.score);
                $display("  actual   cx=%0d cy=%0d w=%0d h=%0d class=%0d score=%0d",
                         got.center_x, got.center_y, got.box_width, got.box_height,
                         got.class_id, got.score);
            end
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            regs.num_classes     = NUM_CLASSES_RST;
            regs.score_threshold = SCORE_THR_RST;
            regs.scale_x         = SCALE_RST;
            regs.scale_y         = SCALE_RST;
            foreach (box_vals[i])
                box_vals[i] = '0;
            top_score = '0;
            top_class = NO_CLASS;
            detections_due.delete();
            dets_due <= 0;
        end else begin
            // outgoing first: a detection never stems from a value of this edge
            if (det.valid && det.ready)
                check_detection();
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_NUM_CLASSES: regs.num_classes     = cfg.data[NCLS_W-1:0];
                    REG_SCORE_THR:   regs.score_threshold = cfg.data[THR_W-1:0];
                    REG_SCALE_X:     regs.scale_x         = cfg.data[SCALE_W-1:0];
                    REG_SCALE_Y:     regs.scale_y         = cfg.data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
                absorb_head_value(item.channel, item.value);
            dets_due <= detections_due.size();
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: anchor-free box decoder testbench
// Directed anchors for the edge cases, then random phases of anchors under
// changing register settings, with random gaps on the head value side and
// random stalls on the detection side. Checking lives in the checker.
// ----------------------------------------------------------------------------
module tb;
    import afbd_pkg::*;

    localparam realtime HALF_PERIOD    = 6.0;
    localparam int      RESET_CYCLES   = 3;
    localparam int      SETTLE_CYCLES  = 10;   // pipeline is three deep
    localparam int      WATCHDOG_LIMIT = 2000;
    localparam int      RANDOM_ITEMS   = 1300;
    localparam int      NUM_PHASES     = 10;
    localparam int      PRESSURE_PHASE = 3;
    localparam int      NUM_REGS       = 4;
    localparam int      CFG_IDX_MAX    = (1 << CFG_IDX_W) - 1;
    localparam int      CH_MAX         = (1 << CH_W) - 1;
    localparam int      VAL_MAX        = (1 << (VAL_W - 1)) - 1;
    localparam int      VAL_MIN        = -(1 << (VAL_W - 1));
    localparam int      REG_MAX        = (1 << CFG_DATA_W) - 1;
    localparam int      UNITY_SCALE    = 4096;  // 1.0 in Q4.12

    // box channel numbers
    localparam logic [CH_W-1:0] CH_CX = CH_W'(0);
    localparam logic [CH_W-1:0] CH_CY = CH_W'(1);
    localparam logic [CH_W-1:0] CH_W_ = CH_W'(2);
    localparam logic [CH_W-1:0] CH_H  = CH_W'(3);
    localparam logic [CH_W-1:0] CH_CLS0 = CH_W'(NUM_BOX_CH);

    typedef enum {ANCHOR_FULL, ANCHOR_STRAY, ANCHOR_TRUNCATED} anchor_shape_t;

    logic clk;
    logic rst_n;

    afbd_cfg_if cfg_bus ();
    afbd_in_if  head_bus ();
    afbd_out_if det_bus ();

    int mismatches;
    int dets_due;
    int idle_cycles;
    int items_done;   // counts only values the decoder acts on
    int n_eff;        // class count after the zero / clamp rules
    int thr_now;
    bit calm;         // no gaps, no stalls while set

    anchor_free_box_decode dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .item  (head_bus),
        .det   (det_bus)
    );

    afbd_detection_checker #(.MAX_CLASSES(MAX_CLASSES_DEF)) det_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_bus),
        .item       (head_bus),
        .det        (det_bus),
        .mismatches (mismatches),
        .dets_due   (dets_due)
    );

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // Watchdog: any transfer on any channel counts as progress
    always @(posedge clk) begin
        if ((cfg_bus.valid && cfg_bus.ready) || (head_bus.valid && head_bus.ready)
            || (det_bus.valid && det_bus.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Detection side: ready runs broken by random stalls
    initial begin : det_sink
        int run_len;
        int stall_len;
        det_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            det_bus.ready <= 1'b1;
            run_len = calm ? 8 : $urandom_range(1, 12);
            repeat (run_len) @(posedge clk);
            stall_len = pick_gap();
            if (stall_len > 0) begin
                det_bus.ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    // num_classes write word: random upper bits, which the block must drop
    function automatic logic [CFG_DATA_W-1:0] ncls_word(input int n);
        logic [CFG_DATA_W-1:0] w;
        w = CFG_DATA_W'($urandom());
        w[NCLS_W-1:0] = NCLS_W'(n);
        return w;
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_value();
        return VAL_W'($urandom());
    endfunction

    // Box values: mostly positive, some around the one-pixel cut, some extremes
    function automatic logic signed [VAL_W-1:0] rand_coord();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return VAL_W'($urandom_range(0, VAL_MAX));
        if (roll < 70)
            return VAL_W'($urandom_range(0, 40));
        if (roll < 74)
            return VAL_W'(VAL_MAX);
        if (roll < 78)
            return VAL_W'(VAL_MIN);
        return rand_value();
    endfunction

    // Class scores: ties, non-positive values and the threshold edge
    function automatic logic signed [VAL_W-1:0] rand_score();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        if (roll < 18)
            return VAL_W'(VAL_MAX);
        if (roll < 22)
            return VAL_W'(VAL_MIN);
        if (roll < 32)
            return VAL_W'(-int'($urandom_range(1, 3000)));
        if (roll < 50)
            return VAL_W'(thr_now + int'($urandom_range(0, 4)) - 2);
        return VAL_W'($urandom_range(0, VAL_MAX));
    endfunction

    // One head value transfer; valid stays up between back-to-back values
    task automatic put_item(input logic [CH_W-1:0] ch, input logic signed [VAL_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            head_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        head_bus.valid   <= 1'b1;
        head_bus.channel <= ch;
        head_bus.value   <= v;
        @(posedge clk);
        while (!head_bus.ready)
            @(posedge clk);
        if (ch < NUM_BOX_CH || int'(ch) - NUM_BOX_CH < n_eff)
            items_done++;
    endtask

    // Register writes; valid is lowered once by the caller's group
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
    endtask

    // All four registers plus a write to an unused index, which must be dropped
    task automatic set_config(input logic [CFG_DATA_W-1:0] ncls, thr, sx, sy);
        write_reg(REG_NUM_CLASSES, ncls);
        write_reg(REG_SCORE_THR, thr);
        write_reg(REG_SCALE_X, sx);
        write_reg(REG_SCALE_Y, sy);
        write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, CFG_IDX_MAX)),
                  CFG_DATA_W'($urandom()));
        cfg_bus.valid <= 1'b0;
        n_eff = int'(ncls[NCLS_W-1:0]);
        if (n_eff == 0)
            n_eff = 1;
        if (n_eff > MAX_CLASSES_DEF)
            n_eff = MAX_CLASSES_DEF;
        thr_now = int'(thr);
    endtask

    // Stop sending, wait for every detection owed, then let the pipe empty
    task automatic drain();
        head_bus.valid <= 1'b0;
        @(posedge clk);
        while (dets_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Box, then class scores. Stray: an out-of-range class channel slips in.
    // Truncated: last class never comes, so the next center x must reset.
    task automatic send_anchor(input anchor_shape_t shape);
        int last;
        int stray_at;
        int k;
        for (k = 0; k < NUM_BOX_CH; k++)
            put_item(CH_W'(k), rand_coord());
        last     = n_eff - 1;
        stray_at = -1;
        if (shape == ANCHOR_TRUNCATED)
            last = int'($urandom_range(0, n_eff - 1)) - 1;
        if (shape == ANCHOR_STRAY)
            stray_at = $urandom_range(0, n_eff - 1);
        for (k = 0; k <= last; k++) begin
            if (k == stray_at)
                put_item(CH_W'($urandom_range(NUM_BOX_CH + n_eff, CH_MAX)), rand_value());
            put_item(CH_W'(NUM_BOX_CH + k), rand_score());
        end
    endtask

    initial begin : stimulus
        int  phase;
        int  phase_end;
        int  roll;
        bit  paused;
        rst_n            <= 1'b0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= '0;
        cfg_bus.data     <= '0;
        head_bus.valid   <= 1'b0;
        head_bus.channel <= '0;
        head_bus.value   <= '0;
        calm    = 1'b0;
        paused  = 1'b0;
        n_eff   = int'(NUM_CLASSES_RST);
        thr_now = int'(SCORE_THR_RST);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // class count zero acts as one; threshold zero lets an all-negative
        // anchor out with no class
        set_config(ncls_word(0), '0, CFG_DATA_W'(UNITY_SCALE), CFG_DATA_W'(UNITY_SCALE));
        put_item(CH_CX, VAL_W'(VAL_MIN));
        put_item(CH_CY, VAL_W'(VAL_MAX));
        put_item(CH_W_, VAL_W'(16));           // exactly one pixel wide: kept
        put_item(CH_H, VAL_W'(16));
        put_item(CH_CLS0, VAL_W'(-1));
        put_item(CH_W'(NUM_BOX_CH + 1), VAL_W'(500));   // past the class count: ignored
        put_item(CH_CX, VAL_W'(VAL_MAX));
        put_item(CH_CY, VAL_W'(VAL_MIN));
        put_item(CH_W_, VAL_W'(VAL_MAX));
        put_item(CH_H, VAL_W'(15));            // under one pixel: dropped
        put_item(CH_CLS0, VAL_W'(VAL_MAX));
        // box is kept across decisions; best score was cleared by the last one
        put_item(CH_H, VAL_W'(VAL_MAX));
        put_item(CH_CLS0, '0);
        drain();

        // class count above the maximum clamps; full threshold; maximum scales saturate width and height
        set_config(ncls_word(31), CFG_DATA_W'(REG_MAX), CFG_DATA_W'(REG_MAX),
                   CFG_DATA_W'(REG_MAX));
        put_item(CH_CX, VAL_W'(5000));
        put_item(CH_CY, VAL_W'(-5000));
        put_item(CH_W_, VAL_W'(100000));
        put_item(CH_H, VAL_W'(VAL_MAX));
        put_item(CH_CLS0, VAL_W'(65535));
        put_item(CH_W'(NUM_BOX_CH + 1), VAL_W'(65535));          // tie: first one wins
        put_item(CH_W'(NUM_BOX_CH + MAX_CLASSES_DEF - 1), VAL_W'(65534));
        put_item(CH_W'(NUM_BOX_CH + 3), VAL_W'(VAL_MAX));        // center x below wipes this
        put_item(CH_CX, VAL_W'(7));
        put_item(CH_W'(NUM_BOX_CH + MAX_CLASSES_DEF - 1), VAL_W'(65535));

        // --- random phases ---
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            case (phase)
                0: set_config(ncls_word(7), CFG_DATA_W'($urandom()),
                              CFG_DATA_W'(UNITY_SCALE), CFG_DATA_W'(UNITY_SCALE));
                1: set_config(ncls_word(MAX_CLASSES_DEF), '0,
                              CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
                2: set_config(ncls_word(1), CFG_DATA_W'(REG_MAX),
                              CFG_DATA_W'(REG_MAX), CFG_DATA_W'(REG_MAX));
                3: set_config(ncls_word(0), CFG_DATA_W'($urandom_range(0, 40000)),
                              CFG_DATA_W'($urandom_range(1024, 20000)),
                              CFG_DATA_W'($urandom_range(1024, 20000)));
                4: set_config(ncls_word($urandom_range(1, 4)), '0, '0,
                              CFG_DATA_W'(UNITY_SCALE));   // zero x scale: all dropped
                5: set_config(ncls_word(31), CFG_DATA_W'(1), CFG_DATA_W'(2048),
                              CFG_DATA_W'(8192));
                default: set_config(ncls_word($urandom_range(0, 31)),
                                    CFG_DATA_W'($urandom_range(0, 70000)),
                                    CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
            endcase
            calm      = (phase == 1) || (phase == 6);
            phase_end = items_done + RANDOM_ITEMS / NUM_PHASES;
            while (items_done < phase_end) begin
                roll = $urandom_range(0, 99);
                if (roll < 75)
                    send_anchor(ANCHOR_FULL);
                else if (roll < 85)
                    send_anchor(ANCHOR_STRAY);
                else if (roll < 93)
                    send_anchor(ANCHOR_TRUNCATED);
                else
                    put_item(CH_W'($urandom_range(0, CH_MAX)), rand_value());
                // hold the head side until every owed detection is out
                if (phase == PRESSURE_PHASE && !paused && items_done > phase_end - 60) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/afbd_pkg.sv
rtl/afbd_in_if.sv
rtl/afbd_out_if.sv
rtl/afbd_cfg_if.sv
rtl/afbd_cfg_regs.sv
rtl/afbd_accum.sv
rtl/afbd_emit.sv
rtl/anchor_free_box_decode.sv
tb/afbd_detection_checker.sv
tb/tb.sv
